// ===== sv/gbp_pkg.sv =====
package gbp_pkg;

  // fixed widths of the item fields
  localparam int FIELD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 5;

  // input actions
  typedef enum logic [1:0] {
    ACT_HEADER = 2'd0,
    ACT_EDGE   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // record kinds
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_EDGE = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_DIAG  = 1'b0;
  localparam logic REG_ALLOW = 1'b1;

  typedef struct packed {
    action_t                     action;
    logic signed [FIELD_W-1:0]   rhs_value;
    logic signed [FIELD_W-1:0]   diag_value;
    logic signed [FIELD_W-1:0]   msg_mean_in;
    logic signed [FIELD_W-1:0]   msg_prec_in;
    logic signed [FIELD_W-1:0]   edge_weight;
  } in_item_t;

  typedef struct packed {
    logic                        record_kind;
    logic [IDX_W-1:0]            edge_index;
    logic signed [FIELD_W-1:0]   mean_out;
    logic signed [FIELD_W-1:0]   prec_out;
    logic                        zero_divisor;
    logic                        last_record;
  } out_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]   mean;
    logic signed [FIELD_W-1:0]   prec;
    logic signed [FIELD_W-1:0]   weight;
  } edge_entry_t;

endpackage

// ===== sv/gaussian_bp_node_update.sv =====
// Header and edge beats are absorbed in the idle state.
// A finish beat runs a bit-serial sequencer: the node record takes DW restoring
// division steps (one per cycle, DW = max(VALUE_BITS+40, 64)), and each edge
// message a store read, a setup step, 32 shift-add multiply steps and DW
// division steps. A zero divisor skips the multiply and the division.
// Synchronous active-low reset clears the sums, edge count and registers.
module gaussian_bp_node_update
  import gbp_pkg::*;
#(
  parameter int MAX_DEGREE = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ACC      = VALUE_BITS + 8;
  localparam int OB       = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int EW       = ((ACC > FIELD_W + 1) ? ACC : FIELD_W + 1) + 1;
  localparam int DW       = (ACC + FIELD_W > 2 * FIELD_W) ? ACC + FIELD_W : 2 * FIELD_W;
  localparam int EDGE_CAP = (MAX_DEGREE < 32) ? MAX_DEGREE : 32;
  localparam int IW       = (EDGE_CAP > 1) ? $clog2(EDGE_CAP) : 1;
  localparam int CW       = $clog2(EDGE_CAP + 1);
  localparam int KW       = $clog2(DW + 1);

  localparam logic [EW-1:0]  ACC_MAX_E = {{(EW-ACC+1){1'b0}}, {(ACC-1){1'b1}}};
  localparam logic [EW-1:0]  ACC_MIN_E = ~ACC_MAX_E;
  localparam logic [ACC-1:0] OUT_MAX_A = {{(ACC-OB+1){1'b0}}, {(OB-1){1'b1}}};
  localparam logic [ACC-1:0] OUT_MIN_A = ~OUT_MAX_A;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SUB, S_MUL, S_DIV, S_EMIT
  } state_t;

  // saturate a wide sum to the accumulator width
  function automatic logic signed [ACC-1:0] sat_acc(input logic signed [EW-1:0] v);
    logic signed [ACC-1:0] r;
    if (v > $signed(ACC_MAX_E))      r = $signed(ACC_MAX_E[ACC-1:0]);
    else if (v < $signed(ACC_MIN_E)) r = $signed(ACC_MIN_E[ACC-1:0]);
    else                             r = v[ACC-1:0];
    return r;
  endfunction

  // saturate an accumulator value to the output range, place in a field
  function automatic logic signed [FIELD_W-1:0] sat_out(input logic signed [ACC-1:0] v);
    logic signed [OB-1:0] r;
    if (v > $signed(OUT_MAX_A))      r = $signed(OUT_MAX_A[OB-1:0]);
    else if (v < $signed(OUT_MIN_A)) r = $signed(OUT_MIN_A[OB-1:0]);
    else                             r = v[OB-1:0];
    return FIELD_W'(r);
  endfunction

  function automatic logic [ACC-1:0] mag_acc(input logic signed [ACC-1:0] v);
    return v[ACC-1] ? ACC'(-v) : ACC'(v);
  endfunction

  function automatic logic [FIELD_W-1:0] mag_fld(input logic signed [FIELD_W-1:0] v);
    return v[FIELD_W-1] ? FIELD_W'(-v) : FIELD_W'(v);
  endfunction

  // clamp a quotient to its limit and apply the sign
  function automatic logic signed [FIELD_W-1:0] quot_res(input logic [OB:0] q,
                                                         input logic sticky,
                                                         input logic neg);
    logic [OB:0]          lim;
    logic [OB:0]          qv;
    logic [OB:0]          rv;
    logic signed [OB-1:0] rs;
    lim = (OB+1)'(1) << (OB - 1);
    if (!neg) lim = lim - (OB+1)'(1);
    qv = (sticky || q > lim) ? lim : q;
    rv = neg ? (OB+1)'(-qv) : qv;
    rs = $signed(rv[OB-1:0]);
    return FIELD_W'(rs);
  endfunction

  state_t                  state_r, state_nxt;
  logic signed [31:0]      diag_reg_r, diag_reg_nxt;
  logic                    allow_r, allow_nxt;
  logic signed [ACC-1:0]   mean_sum_r, mean_sum_nxt;
  logic signed [ACC-1:0]   prec_sum_r, prec_sum_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic                    kind_r, kind_nxt;
  logic                    jz_r, jz_nxt;
  logic                    nega_r, nega_nxt;
  logic                    negb_r, negb_nxt;
  logic [ACC-1:0]          d_r, d_nxt;
  logic [DW-1:0]           pa_r, pa_nxt;
  logic [DW-1:0]           pb_r, pb_nxt;
  logic [DW-1:0]           ma_r, ma_nxt;
  logic [DW-1:0]           mb_r, mb_nxt;
  logic [FIELD_W-1:0]      w_r, w_nxt;
  logic [ACC-1:0]          rema_r, rema_nxt;
  logic [ACC-1:0]          remb_r, remb_nxt;
  logic [OB:0]             qa_r, qa_nxt;
  logic [OB:0]             qb_r, qb_nxt;
  logic                    sta_r, sta_nxt;
  logic                    stb_r, stb_nxt;
  logic [KW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  edge_entry_t             mem [EDGE_CAP];
  edge_entry_t             rd_data_r;
  logic                    mem_we;
  edge_entry_t             mem_wdata;

  logic                    in_acc;
  logic                    cfg_wr;
  logic                    slot_free;
  logic                    ld_last;
  logic [ACC:0]            ra, rb;
  logic signed [ACC-1:0]   muij, jij;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign slot_free = !out_valid_r || !out_stall;

  // register read
  always_comb begin
    case (paddr[2])
      REG_DIAG:  prdata = diag_reg_r;
      REG_ALLOW: prdata = {31'd0, allow_r};
      default:   prdata = '0;
    endcase
  end

  // difference terms of the current edge
  assign muij = sat_acc(EW'(mean_sum_r) - EW'(rd_data_r.mean));
  assign jij  = sat_acc(EW'(prec_sum_r) - EW'(rd_data_r.prec));

  // one restoring step for each divider
  assign ra = {rema_r, pa_r[DW-1]};
  assign rb = {remb_r, pb_r[DW-1]};

  always_comb begin
    state_nxt     = state_r;
    diag_reg_nxt  = diag_reg_r;
    allow_nxt     = allow_r;
    mean_sum_nxt  = mean_sum_r;
    prec_sum_nxt  = prec_sum_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    jz_nxt        = jz_r;
    nega_nxt      = nega_r;
    negb_nxt      = negb_r;
    d_nxt         = d_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    w_nxt         = w_r;
    rema_nxt      = rema_r;
    remb_nxt      = remb_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    sta_nxt       = sta_r;
    stb_nxt       = stb_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wdata     = '{mean: in_data.msg_mean_in, prec: in_data.msg_prec_in,
                      weight: in_data.edge_weight};
    ld_last       = 1'b0;

    // configuration writes
    if (cfg_wr) begin
      case (paddr[2])
        REG_DIAG:  diag_reg_nxt = $signed(pwdata);
        REG_ALLOW: allow_nxt    = pwdata[0];
        default:   ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.action)
            ACT_HEADER: begin
              mean_sum_nxt = sat_acc(EW'(in_data.rhs_value));
              prec_sum_nxt = sat_acc(EW'(in_data.diag_value) + EW'(diag_reg_r));
              count_nxt    = '0;
            end
            ACT_EDGE: begin
              if (count_r < CW'(EDGE_CAP)) begin
                mem_we       = 1'b1;
                mean_sum_nxt = sat_acc(EW'(mean_sum_r) + EW'(in_data.msg_mean_in));
                prec_sum_nxt = sat_acc(EW'(prec_sum_r) + EW'(in_data.msg_prec_in));
                count_nxt    = count_r + CW'(1);
              end
            end
            ACT_FINISH: begin
              // node record: (|mu| << 16) / |J|
              kind_nxt = KIND_NODE;
              idx_nxt  = '0;
              jz_nxt   = (prec_sum_r == '0);
              nega_nxt = mean_sum_r[ACC-1] ^ prec_sum_r[ACC-1];
              negb_nxt = 1'b0;
              d_nxt    = mag_acc(prec_sum_r);
              pa_nxt   = DW'(mag_acc(mean_sum_r)) << FRAC_BITS;
              pb_nxt   = '0;
              rema_nxt = '0;
              remb_nxt = '0;
              qa_nxt   = '0;
              qb_nxt   = '0;
              sta_nxt  = 1'b0;
              stb_nxt  = 1'b0;
              cnt_nxt  = '0;
              state_nxt = (prec_sum_r == '0) ? S_EMIT : S_DIV;
            end
            default: ;
          endcase
        end
      end

      // wait for the store read
      S_RD: state_nxt = S_SUB;

      // set up multiply and division for this edge
      S_SUB: begin
        jz_nxt   = (jij == '0);
        nega_nxt = !(rd_data_r.weight[FIELD_W-1] ^ muij[ACC-1] ^ jij[ACC-1]);
        negb_nxt = !jij[ACC-1];
        d_nxt    = mag_acc(jij);
        ma_nxt   = DW'(mag_acc(muij));
        mb_nxt   = DW'(mag_fld(rd_data_r.weight));
        w_nxt    = mag_fld(rd_data_r.weight);
        pa_nxt   = '0;
        pb_nxt   = '0;
        rema_nxt = '0;
        remb_nxt = '0;
        qa_nxt   = '0;
        qb_nxt   = '0;
        sta_nxt  = 1'b0;
        stb_nxt  = 1'b0;
        cnt_nxt  = '0;
        state_nxt = (jij == '0) ? S_EMIT : S_MUL;
      end

      // shift-add both products, one weight bit a cycle
      S_MUL: begin
        if (w_r[0]) begin
          pa_nxt = pa_r + ma_r;
          pb_nxt = pb_r + mb_r;
        end
        ma_nxt = ma_r << 1;
        mb_nxt = mb_r << 1;
        w_nxt  = w_r >> 1;
        if (cnt_r == KW'(FIELD_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + KW'(1);
        end
      end

      // one quotient bit a cycle on both dividers
      S_DIV: begin
        if (ra >= {1'b0, d_r}) begin
          rema_nxt = ACC'(ra - {1'b0, d_r});
          qa_nxt   = {qa_r[OB-1:0], 1'b1};
        end else begin
          rema_nxt = ACC'(ra);
          qa_nxt   = {qa_r[OB-1:0], 1'b0};
        end
        if (rb >= {1'b0, d_r}) begin
          remb_nxt = ACC'(rb - {1'b0, d_r});
          qb_nxt   = {qb_r[OB-1:0], 1'b1};
        end else begin
          remb_nxt = ACC'(rb);
          qb_nxt   = {qb_r[OB-1:0], 1'b0};
        end
        sta_nxt = sta_r | qa_r[OB];
        stb_nxt = stb_r | qb_r[OB];
        pa_nxt  = pa_r << 1;
        pb_nxt  = pb_r << 1;
        if (cnt_r == KW'(DW - 1)) state_nxt = S_EMIT;
        else                      cnt_nxt   = cnt_r + KW'(1);
      end

      // load the result beat when the slot is free, then advance to the next edge or return to idle
      S_EMIT: begin
        if (kind_r == KIND_NODE) ld_last = (count_r == '0);
        else                     ld_last = (CW'(idx_r) + CW'(1) == count_r);
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.record_kind  = kind_r;
          out_data_nxt.edge_index   = IDX_W'(idx_r);
          out_data_nxt.last_record  = ld_last;
          out_data_nxt.zero_divisor = jz_r && !allow_r;
          if (jz_r) begin
            out_data_nxt.mean_out = (kind_r == KIND_NODE && allow_r) ?
                                    sat_out(mean_sum_r) : '0;
            out_data_nxt.prec_out = '0;
          end else if (kind_r == KIND_NODE) begin
            out_data_nxt.mean_out = quot_res(qa_r, sta_r, nega_r);
            out_data_nxt.prec_out = sat_out(prec_sum_r);
          end else begin
            out_data_nxt.mean_out = quot_res(qa_r, sta_r, nega_r);
            out_data_nxt.prec_out = quot_res(qb_r, stb_r, negb_r);
          end
          if (ld_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = (kind_r == KIND_NODE) ? '0 : idx_r + IW'(1);
            kind_nxt  = KIND_EDGE;
            state_nxt = S_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    kind_r     <= kind_nxt;
    jz_r       <= jz_nxt;
    nega_r     <= nega_nxt;
    negb_r     <= negb_nxt;
    d_r        <= d_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    w_r        <= w_nxt;
    rema_r     <= rema_nxt;
    remb_r     <= remb_nxt;
    qa_r       <= qa_nxt;
    qb_r       <= qb_nxt;
    sta_r      <= sta_nxt;
    stb_r      <= stb_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      diag_reg_r  <= '0;
      allow_r     <= 1'b0;
      mean_sum_r  <= '0;
      prec_sum_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      diag_reg_r  <= diag_reg_nxt;
      allow_r     <= allow_nxt;
      mean_sum_r  <= mean_sum_nxt;
      prec_sum_r  <= prec_sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // edge store: write on an edge beat, registered read at the walk index
  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[IW-1:0]] <= mem_wdata;
    rd_data_r <= mem[idx_r];
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(EDGE_CAP))
    else $error("edge count beyond capacity");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> d_r != '0)
    else $error("division started with zero divisor");

  a_mul_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> !jz_r)
    else $error("multiply on a zero-divisor edge");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && slot_free && ld_last) |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle after last record");
`endif

endmodule

// ===== tb/sv/gbp_result_checker.sv =====
// Watches the input, result and register channels of the node update block,
// predicts every record a finish beat produces and compares it field by field.
module gbp_result_checker
  import gbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          records_pending,
  output int          fail_count,
  output int          records_checked,
  output int          zero_div_seen
);

  localparam int NODE_CAP = 32;

  // predictor state
  logic signed [31:0] diag_reg;
  logic               allow_zero;
  logic signed [39:0] mean_acc;
  logic signed [39:0] prec_acc;
  edge_entry_t        edge_mem [NODE_CAP];
  int                 edge_cnt;
  out_item_t          expected_records [$];

  function automatic logic signed [39:0] sat40(logic signed [63:0] v);
    if (v > 64'sd549755813887) return 40'sh7F_FFFF_FFFF;
    if (v < -64'sd549755813888) return 40'sh80_0000_0000;
    return v[39:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // truncated quotient, clamped to the 32-bit signed range, then signed
  function automatic logic signed [31:0] clamped_quot(logic [127:0] num,
                                                      logic [63:0] den,
                                                      bit neg);
    logic [127:0] q;
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    q = num / {64'd0, den};
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // node record then one message per stored edge
  task automatic predict_finish();
    out_item_t          rec;
    logic signed [63:0] mu;
    logic signed [63:0] jj;
    logic signed [63:0] wt;
    logic [127:0]       num;
    mu = mean_acc;
    jj = prec_acc;
    rec = '0;
    rec.record_kind = KIND_NODE;
    rec.last_record = (edge_cnt == 0);
    if (jj == 0) begin
      if (allow_zero) rec.mean_out = sat32(mu);
      else rec.zero_divisor = 1'b1;
    end else begin
      num = {64'd0, magnitude(mu)} << 16;
      rec.mean_out = clamped_quot(num, magnitude(jj), (mu < 0) != (jj < 0));
      rec.prec_out = sat32(jj);
    end
    expected_records.push_back(rec);
    for (int i = 0; i < edge_cnt; i++) begin
      rec = '0;
      rec.record_kind = KIND_EDGE;
      rec.edge_index = i[IDX_W-1:0];
      rec.last_record = (i + 1 == edge_cnt);
      mu = sat40(64'(mean_acc) - 64'(edge_mem[i].mean));
      jj = sat40(64'(prec_acc) - 64'(edge_mem[i].prec));
      wt = edge_mem[i].weight;
      if (jj == 0) begin
        rec.zero_divisor = !allow_zero;
      end else begin
        num = {64'd0, magnitude(wt)} * {64'd0, magnitude(mu)};
        rec.mean_out = clamped_quot(num, magnitude(jj), !((wt < 0) ^ (mu < 0) ^ (jj < 0)));
        num = {64'd0, magnitude(wt)} * {64'd0, magnitude(wt)};
        rec.prec_out = clamped_quot(num, magnitude(jj), !(jj < 0));
      end
      expected_records.push_back(rec);
    end
  endtask

  task automatic compare_record(out_item_t got);
    out_item_t want;
    if (expected_records.size() == 0) begin
      $display("%0t: unexpected record, expected none, got %h", $time, got);
      fail_count++;
      return;
    end
    want = expected_records.pop_front();
    records_checked++;
    if (got.zero_divisor) zero_div_seen++;
    if (got.record_kind !== want.record_kind) begin
      $display("%0t: record_kind expected %0d got %0d", $time, want.record_kind,
               got.record_kind);
      fail_count++;
    end
    if (got.edge_index !== want.edge_index) begin
      $display("%0t: edge_index expected %0d got %0d", $time, want.edge_index,
               got.edge_index);
      fail_count++;
    end
    if (got.mean_out !== want.mean_out) begin
      $display("%0t: mean_out expected %h got %h", $time, want.mean_out, got.mean_out);
      fail_count++;
    end
    if (got.prec_out !== want.prec_out) begin
      $display("%0t: prec_out expected %h got %h", $time, want.prec_out, got.prec_out);
      fail_count++;
    end
    if (got.zero_divisor !== want.zero_divisor) begin
      $display("%0t: zero_divisor expected %0d got %0d", $time, want.zero_divisor,
               got.zero_divisor);
      fail_count++;
    end
    if (got.last_record !== want.last_record) begin
      $display("%0t: last_record expected %0d got %0d", $time, want.last_record,
               got.last_record);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    records_checked = 0;
    zero_div_seen = 0;
    records_pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      diag_reg = '0;
      allow_zero = 1'b0;
      mean_acc = '0;
      prec_acc = '0;
      edge_cnt = 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DIAG) diag_reg = pwdata;
        else allow_zero = pwdata[0];
      end
      // absorb an input beat
      if (in_valid && !in_stall) begin
        case (in_data.action)
          ACT_HEADER: begin
            mean_acc = sat40(64'(in_data.rhs_value));
            prec_acc = sat40(64'(in_data.diag_value) + 64'(diag_reg));
            edge_cnt = 0;
          end
          ACT_EDGE: begin
            if (edge_cnt < NODE_CAP) begin
              edge_mem[edge_cnt] = {in_data.msg_mean_in, in_data.msg_prec_in,
                                    in_data.edge_weight};
              mean_acc = sat40(64'(mean_acc) + 64'(in_data.msg_mean_in));
              prec_acc = sat40(64'(prec_acc) + 64'(in_data.msg_prec_in));
              edge_cnt++;
            end
          end
          ACT_FINISH: predict_finish();
          default: ;
        endcase
      end
      // check a result beat
      if (out_valid && !out_stall) compare_record(out_data);
    end
    records_pending = expected_records.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Stimulus and verdict for the node update block; checking lives in the checker.
module tb_top;
  import gbp_pkg::*;

  localparam int ITEM_TARGET = 280;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE      = 150;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int records_pending;
  int fail_count;
  int records_checked;
  int zero_div_seen;

  int items_sent;
  int finishes_sent;
  int idle_cycles;
  bit quiet;
  bit hold_req;
  logic signed [31:0] cur_diag_reg;

  gaussian_bp_node_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gbp_result_checker result_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .records_pending(records_pending), .fail_count(fail_count),
    .records_checked(records_checked), .zero_div_seen(zero_div_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Q16.16 operand: mostly moderate, sometimes full range or an extreme
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic in_item_t make_item(action_t act);
    in_item_t it;
    it = '0;
    it.action = act;
    if (act == ACT_HEADER) begin
      it.rhs_value = pick_value();
      it.diag_value = pick_value();
    end else if (act == ACT_EDGE) begin
      it.msg_mean_in = pick_value();
      it.msg_prec_in = pick_value();
      it.edge_weight = pick_value();
    end else if (act == ACT_NONE) begin
      it = {ACT_NONE, 160'($urandom) ^ {$urandom, $urandom, $urandom, $urandom, $urandom}};
    end
    return it;
  endfunction

  // offer one beat, idling first at random, and hold it until taken
  task automatic send_beat(in_item_t it);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (it.action == ACT_FINISH) finishes_sent++;
  endtask

  task automatic send_action(action_t act);
    send_beat(make_item(act));
  endtask

  // pause the sender until every record has arrived and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_DIAG) cur_diag_reg = val;
  endtask

  // one node: header, some edges, finish
  task automatic send_node(int n_edges, bit zero_case);
    in_item_t it;
    it = make_item(ACT_HEADER);
    if (zero_case) it.diag_value = -cur_diag_reg;
    send_beat(it);
    for (int i = 0; i < n_edges; i++) begin
      it = make_item(ACT_EDGE);
      // cancel the diagonal so the node or the edge divisor lands on zero
      if (zero_case && i == 0 && $urandom_range(1)) it.msg_prec_in = 32'sd0;
      send_beat(it);
    end
    send_action(ACT_FINISH);
  endtask

  task automatic random_phase(int count);
    int stop;
    int n;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case ($urandom_range(19))
        0: send_action(ACT_NONE);
        1: send_action(ACT_FINISH);
        2: send_action(ACT_EDGE);
        default: begin
          n = ($urandom_range(15) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 4);
          send_node(n, $urandom_range(5) == 0);
        end
      endcase
    end
  endtask

  // result side: random stall, long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 6);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    finishes_sent = 0;
    idle_cycles = 0;
    cur_diag_reg = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: finish before any header, unused action, field extremes
    send_action(ACT_FINISH);
    send_action(ACT_NONE);
    it = '0;
    it.action = ACT_HEADER;
    it.rhs_value = 32'sh7FFF_FFFF;
    it.diag_value = 32'sh8000_0000;
    send_beat(it);
    it = '0;
    it.action = ACT_EDGE;
    it.msg_mean_in = 32'sh8000_0000;
    it.msg_prec_in = 32'sh7FFF_FFFF;
    it.edge_weight = 32'sh8000_0000;
    send_beat(it);
    it.msg_mean_in = 32'sh7FFF_FFFF;
    it.msg_prec_in = 32'sh8000_0000;
    it.edge_weight = 32'sh7FFF_FFFF;
    send_beat(it);
    send_action(ACT_FINISH);
    send_action(ACT_FINISH);
    // zero node divisor, no edges
    it = '0;
    it.action = ACT_HEADER;
    it.rhs_value = 32'sh0003_0000;
    send_beat(it);
    send_action(ACT_FINISH);
    // zero edge divisor: one edge whose precision alone makes the sum
    it.diag_value = 32'sh0000_0000;
    send_beat(it);
    it = '0;
    it.action = ACT_EDGE;
    it.msg_mean_in = 32'sh0001_0000;
    it.msg_prec_in = 32'sh0002_0000;
    it.edge_weight = 32'shFFFF_0000;
    send_beat(it);
    send_action(ACT_FINISH);
    drain();

    // null-variance mode with the same zero cases
    write_reg(REG_ALLOW, 32'd1);
    write_reg(REG_DIAG, 32'sh0001_0000);
    send_node(0, 1'b1);
    send_node(1, 1'b1);
    send_node(2, 1'b0);
    drain();

    // random phases across register settings, the extremes among them
    write_reg(REG_DIAG, 32'sh7FFF_FFFF);
    write_reg(REG_ALLOW, 32'd0);
    random_phase(50);
    drain();

    write_reg(REG_DIAG, 32'sh8000_0000);
    write_reg(REG_ALLOW, 32'd1);
    quiet = 1'b1;
    random_phase(50);
    drain();
    quiet = 1'b0;

    write_reg(REG_DIAG, 32'sh0000_0000);
    write_reg(REG_ALLOW, 32'd0);
    hold_req = 1'b1;
    send_node(6, 1'b0);
    for (int i = 0; i < 6; i++) send_action(ACT_FINISH);
    random_phase(40);
    drain();

    while (items_sent < ITEM_TARGET) begin
      write_reg(REG_DIAG, pick_value());
      write_reg(REG_ALLOW, {31'd0, 1'($urandom_range(1))});
      random_phase(40);
      drain();
    end

    $display("Sent %0d beats (%0d finishes); checked %0d records, %0d with zero divisor.",
             items_sent, finishes_sent, records_checked, zero_div_seen);
    if (fail_count == 0 && records_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gbp_pkg.sv
sv/gaussian_bp_node_update.sv
tb/sv/gbp_result_checker.sv
tb/sv/tb_top.sv
